// ----- rtl/running_mean_variance_tracker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the running mean/variance tracker
// Shared wrappers that clock assertions on clk and mask them during reset.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_TRACKER_CORE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_TRACKER_CORE_DEFINES_SVH

// General property, clocked on clk, off while rst_n is low.
`define RMVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must hold on every result the block presents.
`define RMVT_ASSERT_RESULT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) out_ch.valid |-> (cond)) \
    else $error(msg);

`endif

// ----- rtl/rmvt_pkg.sv -----
// ----------------------------------------------------------------------------
// rmvt_pkg
// Widths, step counts and limits shared by the tracker, its channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmvt_pkg;

  // Sample and fixed-point format
  localparam int SAMPLE_BITS   = 32;   // valid low bits of a sample, 8..32
  localparam int FRACTION_BITS = 16;   // fraction bits of mean/spread/std, 0..16

  // Field widths
  localparam int IN_W     = 32;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 64;
  localparam int MEAN_W   = 48;
  localparam int SPREAD_W = 63;
  localparam int STD_W    = 48;

  // Datapath widths
  localparam int ADD_W    = 64;            // shared adder/subtractor
  localparam int REM_W    = COUNT_W;       // divider remainder
  localparam int ROOT_W   = 40;            // square root result
  localparam int WQ_W     = 2 * ROOT_W;    // dividend/quotient/radicand shifter
  localparam int MAG_W    = 49;            // multiplier operand magnitude
  localparam int TMP_W    = MAG_W + 1;     // signed deviation
  localparam int ACC_W    = MAG_W + 1;     // multiplier upper half / sqrt remainder
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int SQ_SH_W  = SQ_REM_W + 2;

  // Iteration counts
  localparam int STEP_W     = 7;
  localparam int MEAN_STEPS = 32 + FRACTION_BITS;
  localparam int STD_STEPS  = SPREAD_W + FRACTION_BITS;
  localparam int MUL_STEPS  = MAG_W;

  // Limits and masks
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;
  localparam logic [MEAN_W-1:0]   MEAN_MASK  = {MEAN_W{1'b1}} >> (MEAN_W - MEAN_STEPS);
  localparam logic [WQ_W-1:0]     STD_MASK   = {WQ_W{1'b1}} >> (WQ_W - STD_STEPS);

endpackage

`default_nettype wire

// ----- rtl/rmvt_in_if.sv -----
// ----------------------------------------------------------------------------
// rmvt_in_if
// Sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmvt_in_if import rmvt_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
  modport mon    (input valid, input sample, input ready);

endinterface

`default_nettype wire

// ----- rtl/rmvt_out_if.sv -----
// ----------------------------------------------------------------------------
// rmvt_out_if
// Result channel: valid/ready handshake carrying the full statistics set.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmvt_out_if import rmvt_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] count;
  logic signed [IN_W-1:0]    minimum;
  logic signed [IN_W-1:0]    maximum;
  logic signed [TOTAL_W-1:0] total;
  logic signed [MEAN_W-1:0]  mean;
  logic       [SPREAD_W-1:0] spread_sum;
  logic          [STD_W-1:0] std_dev;
  logic                      saturated;

  modport source (output valid, output count, output minimum, output maximum,
                  output total, output mean, output spread_sum, output std_dev,
                  output saturated, input ready);
  modport sink   (input valid, input count, input minimum, input maximum,
                  input total, input mean, input spread_sum, input std_dev,
                  input saturated, output ready);
  modport mon    (input valid, input count, input minimum, input maximum,
                  input total, input mean, input spread_sum, input std_dev,
                  input saturated, input ready);

endinterface

`default_nettype wire

// ----- rtl/running_mean_variance_tracker_core.sv -----
// ----------------------------------------------------------------------------
// running_mean_variance_tracker_core
// Welford running mean/variance tracker with min, max, total and std deviation.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch: one signed sample per transfer. in_ch.ready is high only while the
//    block is idle; it drops for the whole computation of a sample.
//  - out_ch: one result per sample with count, min, max, total, mean (Q32.16),
//    spread_sum (Q.16, saturating), std_dev (Q32.16) and the saturated flag.
//  - Computation shares the single 64-bit adder. A normal sample runs 48
//    divide steps for the mean, 49 shift-add multiply steps, 79 divide
//    steps for spread/count and 40 square-root steps, with setup states
//    between them. The first sample and samples dropped at full count skip
//    straight to the spread/count divide and the square root.
//  - The result sits in an output register; ready is raised again while it
//    waits. If the receiver stalls past the next sample's computation, the
//    block holds in its final state until the register frees.
//  - Reset (rst_n low, synchronous) clears all statistics and the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance_tracker_core import rmvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rmvt_in_if.sink    in_ch,
  rmvt_out_if.source out_ch
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TOT  = 4'd1;   // total += x
  localparam logic [3:0] ST_ABS  = 4'd2;   // |total|, set up mean divide
  localparam logic [3:0] ST_MDIV = 4'd3;   // |total| * 2^F / count
  localparam logic [3:0] ST_DIFD = 4'd4;   // d = xq - old mean
  localparam logic [3:0] ST_ABSD = 4'd5;   // |d|
  localparam logic [3:0] ST_MEAN = 4'd6;   // apply sign to new mean
  localparam logic [3:0] ST_DIFE = 4'd7;   // e = xq - new mean
  localparam logic [3:0] ST_ABSE = 4'd8;   // |e|, set up multiply
  localparam logic [3:0] ST_MUL  = 4'd9;   // |d| * |e|
  localparam logic [3:0] ST_SPR  = 4'd10;  // spread +/- term, set up std divide
  localparam logic [3:0] ST_SDIV = 4'd11;  // spread * 2^F / count
  localparam logic [3:0] ST_SQI  = 4'd12;  // set up square root
  localparam logic [3:0] ST_SQRT = 4'd13;  // integer square root
  localparam logic [3:0] ST_OUT  = 4'd14;  // load result register

  // Control and statistics state
  logic [3:0]                state_r, state_nxt;
  logic [STEP_W-1:0]         cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic signed [IN_W-1:0]    min_r, min_nxt;
  logic signed [IN_W-1:0]    max_r, max_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic signed [MEAN_W-1:0]  mean_r, mean_nxt;
  logic [SPREAD_W-1:0]       dev_r, dev_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Working registers
  logic signed [IN_W-1:0]    x_r, x_nxt;
  logic                      tneg_r, tneg_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [WQ_W-1:0]           wq_r, wq_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [MAG_W-1:0]          md_r, md_nxt;
  logic signed [TMP_W-1:0]   tmp_r, tmp_nxt;
  logic                      dsign_r, dsign_nxt;
  logic                      neg_r, neg_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;

  // Result register
  logic [COUNT_W-1:0]        o_count_r;
  logic signed [IN_W-1:0]    o_min_r, o_max_r;
  logic signed [TOTAL_W-1:0] o_total_r;
  logic signed [MEAN_W-1:0]  o_mean_r;
  logic [SPREAD_W-1:0]       o_spread_r;
  logic [ROOT_W-1:0]         o_root_r;
  logic                      o_sat_r;
  logic                      out_load;

  // Shared adder/subtractor
  logic [ADD_W-1:0]          add_a, add_b;
  logic                      add_sub;
  logic [ADD_W:0]            add_sum;
  logic [ADD_W-1:0]          add_res;
  logic                      add_co;

  // Derived values
  logic                      in_take;
  logic signed [IN_W-1:0]    x_in;
  logic signed [MEAN_W-1:0]  xq;
  logic [TOTAL_W-1:0]        tot_mag;
  logic [MAG_W-1:0]          tmp_mag;
  logic [MEAN_W-1:0]         mean_q;
  logic [ACC_W-1:0]          mul_psum;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         term_sh;
  logic                      term_big;
  logic [SPREAD_W-1:0]       term_lo;
  logic                      spr_sat;
  logic [SQ_SH_W-1:0]        sq_shift;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign x_in     = IN_W'($signed(in_ch.sample[SAMPLE_BITS-1:0]));
  assign xq       = MEAN_W'(x_r) <<< FRACTION_BITS;
  assign tot_mag  = total_r[TOTAL_W-1] ? add_res : total_r;
  assign tmp_mag  = tmp_r[TMP_W-1] ? add_res[MAG_W-1:0] : tmp_r[MAG_W-1:0];
  assign mean_q   = wq_r[MEAN_W-1:0] & MEAN_MASK;
  assign mul_psum = wq_r[0] ? add_res[ACC_W-1:0] : acc_r;
  assign prod     = {acc_r[MAG_W-1:0], wq_r[MAG_W-1:0]};
  assign term_sh  = prod >> FRACTION_BITS;
  assign term_big = |term_sh[PROD_W-1:SPREAD_W];
  assign term_lo  = term_sh[SPREAD_W-1:0];
  assign spr_sat  = term_big || add_res[SPREAD_W];
  assign sq_shift = {acc_r[SQ_REM_W-1:0], wq_r[WQ_W-1 -: 2]};

  // Operand selection for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      ST_TOT: begin
        add_a = total_r;
        add_b = ADD_W'(x_r);
      end
      ST_ABS: begin
        add_b   = total_r;
        add_sub = 1'b1;
      end
      ST_MDIV, ST_SDIV: begin
        add_a   = ADD_W'({rem_r, wq_r[WQ_W-1]});
        add_b   = ADD_W'(count_r);
        add_sub = 1'b1;
      end
      ST_DIFD, ST_DIFE: begin
        add_a   = ADD_W'(xq);
        add_b   = ADD_W'(mean_r);
        add_sub = 1'b1;
      end
      ST_ABSD, ST_ABSE: begin
        add_b   = ADD_W'(tmp_r);
        add_sub = 1'b1;
      end
      ST_MEAN: begin
        add_b   = ADD_W'(mean_q);
        add_sub = 1'b1;
      end
      ST_MUL: begin
        add_a = ADD_W'(acc_r);
        add_b = ADD_W'(md_r);
      end
      ST_SPR: begin
        add_a   = ADD_W'(dev_r);
        add_b   = ADD_W'(term_lo);
        add_sub = neg_r;
      end
      ST_SQRT: begin
        add_a   = ADD_W'(sq_shift);
        add_b   = ADD_W'({root_r, 2'b01});
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {ADD_W{add_sub}}} + (ADD_W+1)'(add_sub);
  assign add_res = add_sum[ADD_W-1:0];
  assign add_co  = add_sum[ADD_W];

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    total_nxt     = total_r;
    mean_nxt      = mean_r;
    dev_nxt       = dev_r;
    ovf_nxt       = ovf_r;
    x_nxt         = x_r;
    tneg_nxt      = tneg_r;
    rem_nxt       = rem_r;
    wq_nxt        = wq_r;
    acc_nxt       = acc_r;
    md_nxt        = md_r;
    tmp_nxt       = tmp_r;
    dsign_nxt     = dsign_r;
    neg_nxt       = neg_r;
    root_nxt      = root_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          x_nxt = x_in;
          if (count_r == COUNT_MAX) begin
            // count full: sample dropped, statistics reported as they are
            ovf_nxt   = 1'b1;
            state_nxt = ST_SDIV;
          end else if (count_r == '0) begin
            min_nxt   = x_in;
            max_nxt   = x_in;
            total_nxt = TOTAL_W'(x_in);
            mean_nxt  = MEAN_W'(x_in) <<< FRACTION_BITS;
            count_nxt = COUNT_W'(1);
            state_nxt = ST_SDIV;
          end else begin
            if (x_in < min_r) min_nxt = x_in;
            if (x_in > max_r) max_nxt = x_in;
            count_nxt = count_r + COUNT_W'(1);
            state_nxt = ST_TOT;
          end
          rem_nxt = '0;
          wq_nxt  = {dev_r, {(WQ_W-SPREAD_W){1'b0}}};
          cnt_nxt = STEP_W'(STD_STEPS);
        end
      end

      ST_TOT: begin
        total_nxt = add_res;
        state_nxt = ST_ABS;
      end

      ST_ABS: begin
        // |total| < count * 2^32, so the upper word is already a valid remainder
        tneg_nxt  = total_r[TOTAL_W-1];
        rem_nxt   = tot_mag[TOTAL_W-1:IN_W];
        wq_nxt    = {tot_mag[IN_W-1:0], {(WQ_W-IN_W){1'b0}}};
        cnt_nxt   = STEP_W'(MEAN_STEPS);
        state_nxt = ST_MDIV;
      end

      ST_MDIV, ST_SDIV: begin
        rem_nxt = add_co ? add_res[REM_W-1:0] : {rem_r[REM_W-2:0], wq_r[WQ_W-1]};
        wq_nxt  = {wq_r[WQ_W-2:0], add_co};
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          state_nxt = (state_r == ST_MDIV) ? ST_DIFD : ST_SQI;
        end
      end

      ST_DIFD: begin
        tmp_nxt   = add_res[TMP_W-1:0];
        state_nxt = ST_ABSD;
      end

      ST_ABSD: begin
        md_nxt    = tmp_mag;
        dsign_nxt = tmp_r[TMP_W-1];
        state_nxt = ST_MEAN;
      end

      ST_MEAN: begin
        mean_nxt  = tneg_r ? add_res[MEAN_W-1:0] : mean_q;
        state_nxt = ST_DIFE;
      end

      ST_DIFE: begin
        tmp_nxt   = add_res[TMP_W-1:0];
        state_nxt = ST_ABSE;
      end

      ST_ABSE: begin
        neg_nxt   = dsign_r ^ tmp_r[TMP_W-1];
        wq_nxt    = WQ_W'(tmp_mag);
        acc_nxt   = '0;
        cnt_nxt   = STEP_W'(MUL_STEPS);
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        // right-shifting shift-add: upper half in acc, multiplier/low half in wq
        acc_nxt              = {1'b0, mul_psum[ACC_W-1:1]};
        wq_nxt[MAG_W-1:0]    = {mul_psum[0], wq_r[MAG_W-1:1]};
        cnt_nxt              = cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          state_nxt = ST_SPR;
        end
      end

      ST_SPR: begin
        if (!neg_r) begin
          dev_nxt = spr_sat ? SPREAD_MAX : add_res[SPREAD_W-1:0];
          if (spr_sat) ovf_nxt = 1'b1;
        end else begin
          // negative term: clamp at zero
          dev_nxt = (term_big || !add_co) ? '0 : add_res[SPREAD_W-1:0];
        end
        rem_nxt   = '0;
        wq_nxt    = {dev_nxt, {(WQ_W-SPREAD_W){1'b0}}};
        cnt_nxt   = STEP_W'(STD_STEPS);
        state_nxt = ST_SDIV;
      end

      ST_SQI: begin
        wq_nxt    = wq_r & STD_MASK;
        acc_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = STEP_W'(ROOT_W);
        state_nxt = ST_SQRT;
      end

      ST_SQRT: begin
        if (add_co) begin
          acc_nxt  = ACC_W'(add_res[SQ_REM_W-1:0]);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          acc_nxt  = ACC_W'(sq_shift[SQ_REM_W-1:0]);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        wq_nxt  = {wq_r[WQ_W-3:0], 2'b00};
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      total_r     <= '0;
      mean_r      <= '0;
      dev_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      total_r     <= total_nxt;
      mean_r      <= mean_nxt;
      dev_r       <= dev_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    tneg_r  <= tneg_nxt;
    rem_r   <= rem_nxt;
    wq_r    <= wq_nxt;
    acc_r   <= acc_nxt;
    md_r    <= md_nxt;
    tmp_r   <= tmp_nxt;
    dsign_r <= dsign_nxt;
    neg_r   <= neg_nxt;
    root_r  <= root_nxt;
    if (out_load) begin
      o_count_r  <= count_r;
      o_min_r    <= min_r;
      o_max_r    <= max_r;
      o_total_r  <= total_r;
      o_mean_r   <= mean_r;
      o_spread_r <= dev_r;
      o_root_r   <= root_r;
      o_sat_r    <= ovf_r;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.count       = o_count_r;
  assign out_ch.minimum     = o_min_r;
  assign out_ch.maximum     = o_max_r;
  assign out_ch.total       = o_total_r;
  assign out_ch.mean        = o_mean_r;
  assign out_ch.spread_sum  = o_spread_r;
  assign out_ch.std_dev     = STD_W'(o_root_r);
  assign out_ch.saturated   = o_sat_r;

endmodule

`default_nettype wire

// ----- rtl/rmvt_checker.sv -----
// ----------------------------------------------------------------------------
// rmvt_checker
// Port-level assertions for the tracker, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_mean_variance_tracker_core_defines.svh"

module rmvt_checker import rmvt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rmvt_in_if.sink    in_ch,
  rmvt_out_if.source out_ch
);

  // a sample transfer starts a multi-cycle computation
  `RMVT_ASSERT(a_busy_after_take, in_ch.valid && in_ch.ready |=> !in_ch.ready, "ready after take")

  // a stalled result stays offered
  `RMVT_ASSERT(a_out_hold, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result dropped")

  // saturation is sticky until reset
  `RMVT_ASSERT(a_sat_sticky, out_ch.valid && out_ch.saturated |=> out_ch.saturated, "flag cleared")

  `RMVT_ASSERT_RESULT(a_count_nonzero, out_ch.count != '0, "result with zero count")

  `RMVT_ASSERT_RESULT(a_min_le_max, out_ch.minimum <= out_ch.maximum, "minimum above maximum")

endmodule

bind running_mean_variance_tracker_core rmvt_checker u_rmvt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

// ----- tb/rmvt_stats_checker.sv -----
// ----------------------------------------------------------------------------
// rmvt_stats_checker
// Watches the sample and result channels, predicts the statistics each sample
// should produce and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvt_stats_checker import rmvt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  rmvt_in_if.mon  in_ch,
  rmvt_out_if.mon out_ch,
  output int      mismatch_count,
  output int      pending_results
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SPREAD_LIMIT = {1'b0, SPREAD_MAX};

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [IN_W-1:0]     minimum;
    logic [IN_W-1:0]     maximum;
    logic [TOTAL_W-1:0]  total;
    logic [MEAN_W-1:0]   mean;
    logic [SPREAD_W-1:0] spread_sum;
    logic [STD_W-1:0]    std_dev;
    logic                saturated;
  } stats_t;

  // Tracker state as the block should hold it
  logic [COUNT_W-1:0] n_seen;
  logic signed [63:0] lo_seen;
  logic signed [63:0] hi_seen;
  logic signed [63:0] sum_seen;
  logic signed [63:0] mean_q;
  logic [63:0]        spread_q;
  logic               sat_q;

  stats_t stats_due[$];
  stats_t want;
  int     fail_cnt;
  int     result_idx;

  assign mismatch_count  = fail_cnt;
  assign pending_results = stats_due.size();

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // total * 2^F / count, truncated toward zero
  function automatic logic signed [63:0] welford_mean(input logic signed [63:0] sum,
                                                      input logic [COUNT_W-1:0] n);
    logic [127:0]       scaled;
    logic signed [63:0] m;
    scaled = ({64'd0, mag64(sum)} << FRACTION_BITS) / n;
    m = scaled[63:0];
    return (sum < 0) ? -m : m;
  endfunction

  // delta * e / 2^F on magnitudes, then signed add with saturation / floor at 0
  function automatic void accumulate_term(input logic signed [63:0] d,
                                          input logic signed [63:0] e);
    logic [127:0] term;
    logic         opposite;
    opposite = (d < 0) != (e < 0);
    term = ({64'd0, mag64(d)} * {64'd0, mag64(e)}) >> FRACTION_BITS;
    if (term == 0) return;
    if (!opposite) begin
      if (term > SPREAD_LIMIT || term[63:0] > SPREAD_LIMIT - spread_q) begin
        spread_q = SPREAD_LIMIT;
        sat_q    = 1'b1;
      end else begin
        spread_q = spread_q + term[63:0];
      end
    end else begin
      if (term > SPREAD_LIMIT || term[63:0] >= spread_q) spread_q = '0;
      else spread_q = spread_q - term[63:0];
    end
  endfunction

  // floor(sqrt(spread * 2^F / count)), bitwise from the top
  function automatic logic [STD_W-1:0] std_of_spread();
    logic [127:0]      radicand;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    if (n_seen == 0) return '0;
    radicand = ({64'd0, spread_q} << FRACTION_BITS) / n_seen;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      if ({88'd0, trial} * {88'd0, trial} <= radicand) root = trial;
    end
    return STD_W'(root);
  endfunction

  function automatic stats_t absorb_sample(input logic [IN_W-1:0] raw);
    logic signed [63:0] x;
    logic signed [63:0] xq;
    logic signed [63:0] prev_mean;
    stats_t             r;
    x  = $signed({32'd0, raw} << (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
    xq = x <<< FRACTION_BITS;
    if (n_seen == COUNT_MAX) begin
      sat_q = 1'b1;            // sample dropped
    end else if (n_seen == 0) begin
      lo_seen  = x;
      hi_seen  = x;
      sum_seen = x;
      mean_q   = xq;
      n_seen   = 1;
    end else begin
      if (x < lo_seen) lo_seen = x;
      if (x > hi_seen) hi_seen = x;
      sum_seen  = sum_seen + x;
      n_seen    = n_seen + 1'b1;
      prev_mean = mean_q;
      mean_q    = welford_mean(sum_seen, n_seen);
      accumulate_term(xq - prev_mean, xq - mean_q);
    end
    r.count      = n_seen;
    r.minimum    = lo_seen[IN_W-1:0];
    r.maximum    = hi_seen[IN_W-1:0];
    r.total      = sum_seen;
    r.mean       = mean_q[MEAN_W-1:0];
    r.spread_sum = spread_q[SPREAD_W-1:0];
    r.std_dev    = std_of_spread();
    r.saturated  = sat_q;
    return r;
  endfunction

  task automatic compare_stat(input string field, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("result %0d %s: expected %h, got %h", result_idx, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_seen     = '0;
      lo_seen    = '0;
      hi_seen    = '0;
      sum_seen   = '0;
      mean_q     = '0;
      spread_q   = '0;
      sat_q      = 1'b0;
      fail_cnt   = 0;
      result_idx = 0;
      stats_due.delete();
    end else begin
      // check results before queuing this edge's sample
      if (out_ch.valid && out_ch.ready) begin
        if (stats_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result %0d: no result expected", result_idx);
        end else begin
          want = stats_due.pop_front();
          compare_stat("count",      64'(want.count),      64'(out_ch.count));
          compare_stat("minimum",    64'(want.minimum),    64'(unsigned'(out_ch.minimum)));
          compare_stat("maximum",    64'(want.maximum),    64'(unsigned'(out_ch.maximum)));
          compare_stat("total",      want.total,           unsigned'(out_ch.total));
          compare_stat("mean",       64'(want.mean),       64'(unsigned'(out_ch.mean)));
          compare_stat("spread_sum", 64'(want.spread_sum), 64'(out_ch.spread_sum));
          compare_stat("std_dev",    64'(want.std_dev),    64'(out_ch.std_dev));
          compare_stat("saturated",  64'(want.saturated),  64'(out_ch.saturated));
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready) stats_due = {stats_due, absorb_sample(in_ch.sample)};
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_running_mean_variance_tracker_core.sv -----
// ----------------------------------------------------------------------------
// tb_running_mean_variance_tracker_core
// Drives samples into the tracker under three idle mixes and lets the checker
// compare every statistics result; prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_running_mean_variance_tracker_core import rmvt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Nothing may go this long without a transfer on either channel. Worst
  // honest case is one full computation plus the longest receiver stall.
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 250;   // a bit over the normal-sample latency
  localparam int ITEMS_PER_PHASE = 400;
  localparam int NUM_OPENING     = 22;

  localparam logic [IN_W-1:0] SAMPLE_HI = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic [IN_W-1:0] SAMPLE_LO = {1'b1, {(IN_W-1){1'b0}}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int mismatches;
  int pending;
  int send_idle_pct = 24;
  int recv_idle_pct = 53;
  int recv_hold     = 0;
  int quiet_cycles  = 0;

  logic [IN_W-1:0] last_sample = '0;

  // Opening samples: first-sample load, repeats (zero delta), sign changes,
  // small and mid values, alternating bit patterns, then both field extremes and two small values.
  // Extremes go near the end because the spread pins at its ceiling once they land.
  logic [IN_W-1:0] opening_samples [NUM_OPENING] = '{
    32'd5, 32'd5, -3, 32'd0, 32'd1, -1, 32'd2, 32'd100, -100,
    32'd32767, -32768, 32'd1234567, -1234567, 32'd65536, -65536,
    32'h5555_5555, 32'hAAAA_AAAA,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -1, 32'd0
  };

  rmvt_in_if  in_ch();
  rmvt_out_if out_ch();

  running_mean_variance_tracker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rmvt_stats_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatches),
    .pending_results (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result receiver: per-cycle random stall, and now and then a long one so
  // the block finishes the next sample while its output register is still full.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(4095) == 0) recv_hold = $urandom_range(500, 100);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on transfers, not on total time
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One sample transfer. Called and returns at a falling edge; valid stays up
  // afterwards so back-to-back samples need no extra assignment.
  task automatic push_sample(input logic [IN_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    last_sample = s;
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Mostly sign-extended values of random width so small magnitudes are
  // common; some repeats of the last sample and a few full-scale extremes.
  function automatic logic [IN_W-1:0] random_sample();
    logic [IN_W-1:0] r;
    int unsigned     pick;
    int unsigned     w;
    pick = $urandom_range(15);
    if (pick == 0) return $urandom_range(1) ? SAMPLE_HI : SAMPLE_LO;
    if (pick < 3) return last_sample;
    w = $urandom_range(IN_W, 1);
    r = $urandom;
    return $signed(r << (IN_W - w)) >>> (IN_W - w);
  endfunction

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    rst_n        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      // phase 0: sender 24% / receiver 53%, phase 1 swapped, phase 2 no idling
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (opening_samples[i]) push_sample(opening_samples[i]);
      end else begin
        drain_results();
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(49) == 0) drain_results();
        push_sample(random_sample());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/rmvt_pkg.sv
rtl/rmvt_in_if.sv
rtl/rmvt_out_if.sv
rtl/running_mean_variance_tracker_core.sv
rtl/rmvt_checker.sv
tb/rmvt_stats_checker.sv
tb/tb_running_mean_variance_tracker_core.sv
